// ===== sv/eem_pkg.sv =====
`default_nettype none

package eem_pkg;

    typedef struct packed {
        logic valid;
        logic value;
    } qbit_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== sv/eem_div.sv =====
`default_nettype none

module eem_div #(
    parameter int OPERAND_BITS = 31
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [OPERAND_BITS-1:0]  dividend,
    input  wire logic [OPERAND_BITS-1:0]  divisor,
    output eem_pkg::qbit_t                qbit,
    output eem_pkg::div_stat_t            stat,
    output logic      [OPERAND_BITS-1:0]  remainder
);

    localparam int CNT_W = $clog2(OPERAND_BITS);

    logic [OPERAND_BITS-1:0] dvd_reg;
    logic [OPERAND_BITS-1:0] dvs_reg;
    logic [OPERAND_BITS-1:0] rem_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic [OPERAND_BITS:0]   rem_shift;
    logic [OPERAND_BITS:0]   diff;
    logic                    ge;
    logic [OPERAND_BITS-1:0] rem_next;

    always_comb begin
        rem_shift = {rem_reg, dvd_reg[OPERAND_BITS-1]};
        ge        = rem_shift >= {1'b0, dvs_reg};
        diff      = rem_shift - {1'b0, dvs_reg};
        rem_next  = ge ? diff[OPERAND_BITS-1:0] : rem_shift[OPERAND_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(OPERAND_BITS - 1);
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[OPERAND_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign qbit      = '{valid: busy_reg, value: ge};
    assign stat      = '{busy: busy_reg, done: done_reg};
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== sv/eem_coef_mac.sv =====
`default_nettype none

module eem_coef_mac #(
    parameter int OPERAND_BITS = 31
) (
    input  wire logic                   aclk,
    input  wire logic                   start,
    input  wire eem_pkg::qbit_t         qbit,
    input  wire logic [OPERAND_BITS:0]  coef,
    output logic      [OPERAND_BITS:0]  acc
);

    logic [OPERAND_BITS:0] acc_reg;
    logic [OPERAND_BITS:0] acc_next;

    // shift in one quotient bit per beat while qbit.valid is high, MSB first
    always_comb begin
        acc_next = {acc_reg[OPERAND_BITS-1:0], 1'b0} + (qbit.value ? coef : '0);
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
        end else if (qbit.valid) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== sv/extended_euclid_modular_inverse.sv =====
// Extended Euclid and modular inverse, one result beat per input beat.
// s_ channel: s_tdata carries operand_a (low) and modulus_b; a beat is
// taken when s_tvalid and s_tready are high. s_tready is high only while
// the block is idle, so one operand pair is in work at a time.
// m_ channel: m_tdata carries coef_x, coef_y, inverse, gcd_value; m_tuser
// carries zero_modulus. The result is held in output registers until
// m_tready takes it; while the receiver stalls, no new beat is taken.
// Operation: each Euclid step is a bit-serial restoring division giving
// OPERAND_BITS quotient bits, with the quotient times each coefficient
// built in the same cycles by shift-and-add; the coefficients are then
// updated in the cycle in which the divider reports done. At most 45
// steps at 31 bits (operand_a below modulus_b costs one extra step).
// A zero modulus gives the result the cycle after its beat. s_tready
// rises again in the cycle after the result beat is taken.
// Reset (aresetn low, synchronous) drops any operation in progress and
// any pending result; the block returns idle with s_tready high.
`default_nettype none

module extended_euclid_modular_inverse #(
    parameter int OPERAND_BITS = 31
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // operand_a, modulus_b, zero fill
    input  wire logic [((2*OPERAND_BITS+7)/8)*8-1:0] s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // coef_x, coef_y, inverse, gcd_value, zero fill
    output logic [((4*OPERAND_BITS+9)/8)*8-1:0]      m_tdata,
    // zero_modulus
    output logic [0:0]                 m_tuser
);

    localparam int N     = OPERAND_BITS;
    localparam int CW    = OPERAND_BITS + 1;
    localparam int OUT_W = ((4*OPERAND_BITS+9)/8)*8;
    localparam int USED  = 2*CW + 2*N;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic [N-1:0]  b_reg;
    logic [N-1:0]  mod_reg;
    logic [CW-1:0] xp_reg, xc_reg, yp_reg, yc_reg;
    logic [CW-1:0] cx_reg, cy_reg;
    logic [N-1:0]  inv_reg, gcd_reg;
    logic          zero_reg;

    logic [N-1:0]  in_a, in_b;
    logic          in_beat;
    logic          div_start;
    logic [N-1:0]  div_dividend, div_divisor;
    logic [N-1:0]  rem;
    logic [CW-1:0] accx, accy;
    logic [CW-1:0] xn_next, yn_next;
    logic [N-1:0]  inv_next;

    eem_pkg::qbit_t     qbit;
    eem_pkg::div_stat_t div_stat;

    assign in_a    = s_tdata[N-1:0];
    assign in_b    = s_tdata[2*N-1:N];
    assign in_beat = s_tvalid && s_tready;

    always_comb begin
        div_start    = 1'b0;
        div_dividend = b_reg;
        div_divisor  = rem;
        case (state_reg)
            ST_IDLE: begin
                div_start    = in_beat && (in_b != '0);
                div_dividend = in_a;
                div_divisor  = in_b;
            end
            ST_DIV: begin
                div_start = div_stat.done && (rem != '0);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
        xn_next  = xp_reg - accx;
        yn_next  = yp_reg - accy;
        inv_next = xc_reg[CW-1] ? (xc_reg[N-1:0] + mod_reg) : xc_reg[N-1:0];
    end

    eem_div #(.OPERAND_BITS(N)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .qbit      (qbit),
        .stat      (div_stat),
        .remainder (rem)
    );

    eem_coef_mac #(.OPERAND_BITS(N)) u_mac_x (
        .aclk  (aclk),
        .start (div_start),
        .qbit  (qbit),
        .coef  (xc_reg),
        .acc   (accx)
    );

    eem_coef_mac #(.OPERAND_BITS(N)) u_mac_y (
        .aclk  (aclk),
        .start (div_start),
        .qbit  (qbit),
        .coef  (yc_reg),
        .acc   (accy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        b_reg   <= in_b;
                        mod_reg <= in_b;
                        xp_reg  <= CW'(1);
                        yp_reg  <= '0;
                        xc_reg  <= '0;
                        yc_reg  <= CW'(1);
                        if (in_b == '0) begin
                            cx_reg    <= '0;
                            cy_reg    <= '0;
                            inv_reg   <= '0;
                            gcd_reg   <= '0;
                            zero_reg  <= 1'b1;
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        if (rem == '0) begin
                            cx_reg    <= xc_reg;
                            cy_reg    <= yc_reg;
                            inv_reg   <= inv_next;
                            gcd_reg   <= b_reg;
                            zero_reg  <= 1'b0;
                            state_reg <= ST_OUT;
                        end else begin
                            xp_reg <= xc_reg;
                            xc_reg <= xn_next;
                            yp_reg <= yc_reg;
                            yc_reg <= yn_next;
                            b_reg  <= rem;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {{(OUT_W - USED){1'b0}}, gcd_reg, inv_reg, cy_reg, cx_reg};
    assign m_tuser  = zero_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and result sides open together");

    a_zero_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("zero modulus result carries data");

    a_gcd_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> gcd_reg != '0)
        else $error("zero gcd for nonzero modulus");

    a_div_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> state_reg == ST_DIV)
        else $error("divider running outside a step");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> $past(div_stat.busy))
        else $error("divider done without a run");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int OPB         = 31;
    localparam int CW          = OPB + 1;
    localparam int S_W         = ((2*OPB+7)/8)*8;
    localparam int M_W         = ((4*OPB+9)/8)*8;
    localparam int CLK_PERIOD  = 12;
    localparam int N_RANDOM    = 400;
    localparam int QUIET_TAIL  = 40;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AT     = 60;
    localparam int DRAIN_WAIT  = 50;

    localparam logic [OPB-1:0] OP_MAX = {OPB{1'b1}};
    localparam logic [OPB-1:0] FIB46  = 31'd1836311903;
    localparam logic [OPB-1:0] FIB45  = 31'd1134903170;

    typedef struct packed {
        logic [OPB-1:0] a;
        logic [OPB-1:0] b;
    } operand_pair_t;

    typedef struct packed {
        logic [CW-1:0]  coef_x;
        logic [CW-1:0]  coef_y;
        logic [OPB-1:0] inverse;
        logic [OPB-1:0] gcd_value;
        logic           zero_modulus;
    } euclid_result_t;

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata  = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;
    logic [0:0]     m_tuser;

    operand_pair_t  operand_q[$];
    euclid_result_t euclid_expected_q[$];
    euclid_result_t pending_result;

    int n_total      = 0;
    int n_accepted   = 0;
    int n_results    = 0;
    int n_zero_mod   = 0;
    int n_coprime    = 0;
    int n_errors     = 0;
    int send_gap     = 0;
    int hold_cnt     = 0;
    bit long_hold_done = 1'b0;

    extended_euclid_modular_inverse #(
        .OPERAND_BITS (OPB)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD/2) aclk = ~aclk;

    function automatic euclid_result_t euclid_predict(input logic [OPB-1:0] a_in,
                                                      input logic [OPB-1:0] b_in);
        logic [63:0] a, b, q, r, xp, yp, xc, yc, xn, yn, inv;
        euclid_result_t res;
        begin
            res = '0;
            if (b_in == '0) begin
                res.zero_modulus = 1'b1;
            end else begin
                a  = 64'(a_in);
                b  = 64'(b_in);
                xp = 64'd1;
                yp = 64'd0;
                xc = 64'd0;
                yc = 64'd1;
                q  = a / b;
                r  = a % b;
                while (r != 64'd0) begin
                    xn = xp - q * xc;
                    yn = yp - q * yc;
                    xp = xc;
                    xc = xn;
                    yp = yc;
                    yc = yn;
                    a  = b;
                    b  = r;
                    q  = a / b;
                    r  = a % b;
                end
                inv = xc[63] ? xc + 64'(b_in) : xc;
                res.coef_x    = xc[CW-1:0];
                res.coef_y    = yc[CW-1:0];
                res.inverse   = inv[OPB-1:0];
                res.gcd_value = b[OPB-1:0];
            end
            return res;
        end
    endfunction

    function automatic operand_pair_t random_pair();
        operand_pair_t p;
        logic [OPB-1:0] k;
        begin
            p.a = OPB'($urandom);
            p.b = OPB'($urandom);
            case ($urandom_range(9))
                4: p.b = '0;
                5: begin
                    p.b = OPB'($urandom_range(1, 1 << 20));
                    k   = OPB'($urandom_range(0, 1023));
                    p.a = p.b * k;
                end
                6, 7: begin
                    p.a = OPB'($urandom_range(0, 255));
                    p.b = OPB'($urandom_range(0, 255));
                end
                8: begin
                    p.a = p.a >> $urandom_range(0, OPB-1);
                    p.b = p.b >> $urandom_range(0, OPB-1);
                end
                9: p.b = OP_MAX;
                default: ;
            endcase
            return p;
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        operand_pair_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                euclid_expected_q.push_back(pending_result);
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (operand_q.size() > 0) begin
                    item = operand_q.pop_front();
                    pending_result = euclid_predict(item.a, item.b);
                    s_tdata  <= {{(S_W-2*OPB){1'b0}}, item.b, item.a};
                    s_tvalid <= 1'b1;
                    if (operand_q.size() > QUIET_TAIL && $urandom_range(3) == 0)
                        send_gap = $urandom_range(1, 7);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        euclid_result_t got, exp_res;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.coef_x       = m_tdata[CW-1:0];
                got.coef_y       = m_tdata[2*CW-1:CW];
                got.inverse      = m_tdata[2*CW+OPB-1:2*CW];
                got.gcd_value    = m_tdata[2*CW+2*OPB-1:2*CW+OPB];
                got.zero_modulus = m_tuser[0];
                if (euclid_expected_q.size() == 0) begin
                    $error("result beat with nothing expected: tdata=%h tuser=%b",
                           m_tdata, m_tuser);
                    n_errors++;
                end else begin
                    exp_res = euclid_expected_q.pop_front();
                    n_results++;
                    if (exp_res.zero_modulus)
                        n_zero_mod++;
                    else if (exp_res.gcd_value == 1)
                        n_coprime++;
                    if (got.coef_x !== exp_res.coef_x) begin
                        $error("coef_x: expected %0d, got %0d",
                               $signed(exp_res.coef_x), $signed(got.coef_x));
                        n_errors++;
                    end
                    if (got.coef_y !== exp_res.coef_y) begin
                        $error("coef_y: expected %0d, got %0d",
                               $signed(exp_res.coef_y), $signed(got.coef_y));
                        n_errors++;
                    end
                    if (got.inverse !== exp_res.inverse) begin
                        $error("inverse: expected %0d, got %0d",
                               exp_res.inverse, got.inverse);
                        n_errors++;
                    end
                    if (got.gcd_value !== exp_res.gcd_value) begin
                        $error("gcd_value: expected %0d, got %0d",
                               exp_res.gcd_value, got.gcd_value);
                        n_errors++;
                    end
                    if (got.zero_modulus !== exp_res.zero_modulus) begin
                        $error("zero_modulus: expected %0b, got %0b",
                               exp_res.zero_modulus, got.zero_modulus);
                        n_errors++;
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && n_results >= HOLD_AT) begin
                // hold off long enough for the sender to back up
                long_hold_done = 1'b1;
                hold_cnt = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (operand_q.size() > QUIET_TAIL && $urandom_range(4) == 0) begin
                hold_cnt = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        operand_pair_t directed[$];
        operand_pair_t p;
        directed = '{
            '{a: '0,        b: '0},
            '{a: 31'd5,     b: '0},
            '{a: OP_MAX,    b: '0},
            '{a: '0,        b: 31'd7},
            '{a: '0,        b: OP_MAX},
            '{a: OP_MAX,    b: OP_MAX},
            '{a: 31'd12,    b: 31'd4},
            '{a: 31'd4,     b: 31'd12},
            '{a: 31'd3,     b: 31'd7},
            '{a: 31'd6,     b: 31'd9},
            '{a: 31'd17,    b: 31'd3120},
            '{a: 31'd1,     b: 31'd1},
            '{a: 31'd1,     b: OP_MAX},
            '{a: OP_MAX,    b: 31'd1},
            '{a: OP_MAX,    b: OP_MAX - 31'd1},
            '{a: OP_MAX - 31'd1, b: OP_MAX},
            '{a: FIB46,     b: FIB45},
            '{a: FIB45,     b: FIB46},
            '{a: OP_MAX,    b: 31'h4000_0000},
            '{a: 31'h4000_0000, b: OP_MAX},
            '{a: 31'h5555_5555, b: 31'h2AAA_AAAA},
            '{a: 31'd1,     b: 31'd2}
        };
        foreach (directed[i])
            operand_q.push_back(directed[i]);
        repeat (N_RANDOM) begin
            p = random_pair();
            operand_q.push_back(p);
        end
        n_total = operand_q.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_accepted < n_total || euclid_expected_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Checked %0d results: %0d zero modulus, %0d coprime pairs with an inverse,",
                 n_results, n_zero_mod, n_coprime);
        $display("  including worst-case Fibonacci operands and a long receiver stall.");
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(64'd30_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/eem_pkg.sv
sv/eem_div.sv
sv/eem_coef_mac.sv
sv/extended_euclid_modular_inverse.sv
tb/sv/tb.sv
